/* rtl/core/lamport_mutex_node_defines.svh */
// Assertion macros used by the checker of the mutual exclusion node.
`ifndef LAMPORT_MUTEX_NODE_DEFINES_SVH
`define LAMPORT_MUTEX_NODE_DEFINES_SVH

// Concurrent assertion that is switched off while the reset is applied.
`define LMN_ASSERT(lbl, clk, rst, prop) \
    lbl: assert property (@(posedge clk) disable iff (rst) prop) \
        else $error("lamport_mutex_node: assertion failed");

// Concurrent assertion that is checked at every edge, reset included.
`define LMN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lamport_mutex_node: assertion failed");

`endif

/* rtl/core/lmn_pkg.sv */
package lmn_pkg;

    localparam int NODES      = 4;
    localparam int ID_W       = 2;
    localparam int STAMP_W    = 32;
    localparam int KIND_W     = 3;
    localparam int OKIND_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = NODES;
    localparam int QDEPTH     = 2;

    localparam logic [STAMP_W-1:0] CLOCK_MAX = '1;

    // Input kinds.
    localparam logic [KIND_W-1:0] KIND_LREQ = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LREL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RREQ = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RREP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RREL = 3'd4;

    // Outgoing message kinds.
    localparam logic [OKIND_W-1:0] OUT_REQ   = 2'd0;
    localparam logic [OKIND_W-1:0] OUT_REP   = 2'd1;
    localparam logic [OKIND_W-1:0] OUT_REL   = 2'd2;
    localparam logic [OKIND_W-1:0] OUT_GRANT = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMBER_MASK = 1'd1;

    typedef enum logic [2:0] {
        OP_LREQ,
        OP_LREL,
        OP_RREQ,
        OP_RREP,
        OP_RREL
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    from_node;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]  own_id;
        logic [NODES-1:0] member_mask;
    } t_cfg;

    typedef struct packed {
        logic [OKIND_W-1:0] kind;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    dest;
        logic               last;
    } t_result;

endpackage

/* rtl/core/lamport_mutex_node.sv */
// One node of Lamport's distributed mutual exclusion scheme. Local request and
// release events and received request, reply and release messages enter on the
// input channel; outgoing request and release broadcasts, replies and the grant
// of the critical section leave on the output channel, each tagged with the
// node's saturating logical clock, and o_last marks the final result of an
// input. The front end takes one transfer per cycle unless its queue is full,
// drops items that cannot have an effect (unknown kinds, messages from this
// node itself, from a node outside the member mask or beyond the node count)
// and queues the rest in a two-entry queue. The back end retires one queued
// command per cycle whenever its output register is free: it updates the
// clock, the pending-request table and the reply bitmap and registers the
// result, so a result passes through the queue and the output register
// before it is offered. A local request that is granted at once yields two
// results and holds the back end for two output transfers; every other item
// yields at most one. The sustained rate is therefore one item per cycle while
// the output is not stalled and no second result is pending. own_id and
// member_mask are written through the configuration port, which is always
// ready, and must only be written while the node is idle.
module lamport_mutex_node (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [lmn_pkg::KIND_W-1:0]     i_kind,
    input  logic [lmn_pkg::STAMP_W-1:0]    i_stamp,
    input  logic [lmn_pkg::ID_W-1:0]       i_from_node,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [lmn_pkg::OKIND_W-1:0]    o_out_kind,
    output logic [lmn_pkg::STAMP_W-1:0]    o_out_stamp,
    output logic [lmn_pkg::ID_W-1:0]       o_dest_node,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lmn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lmn_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lmn_pkg::*;

    t_cfg    r_cfg;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;
    t_cmd    q_in_cmd;
    t_cmd    q_out_cmd;
    t_result result;

    // Configuration registers. The port never holds off a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_id      <= '0;
            r_cfg.member_mask <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_OWN_ID:      r_cfg.own_id      <= i_cfg_data[ID_W-1:0];
                CFG_MEMBER_MASK: r_cfg.member_mask <= i_cfg_data[NODES-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Front end: takes the transfer, classifies it and queues what matters.
    lmn_front u_front (
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_stamp     (i_stamp),
        .i_from_node (i_from_node),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in_cmd)
    );

    // Short queue that lets the front and back ends stall independently.
    lmn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    // Back end: owns the clock and request table and registers the results.
    lmn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_out_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_result  (result)
    );

    assign o_out_kind  = result.kind;
    assign o_out_stamp = result.stamp;
    assign o_dest_node = result.dest;
    assign o_last      = result.last;

endmodule

/* rtl/core/lmn_front.sv */
module lmn_front (
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [lmn_pkg::KIND_W-1:0]   i_kind,
    input  logic [lmn_pkg::STAMP_W-1:0]  i_stamp,
    input  logic [lmn_pkg::ID_W-1:0]     i_from_node,
    input  lmn_pkg::t_cfg                i_cfg,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output lmn_pkg::t_cmd                o_q_cmd
);
    import lmn_pkg::*;

    logic own_ok;
    logic sender_ok;
    logic keep;
    t_op  op;

    // Items that can never have an effect are consumed here and never queued.
    always_comb begin
        own_ok    = int'(i_cfg.own_id) < NODES;
        sender_ok = (int'(i_from_node) < NODES) && (i_from_node != i_cfg.own_id)
                    && i_cfg.member_mask[i_from_node];
        case (i_kind)
            KIND_LREQ: begin
                op   = OP_LREQ;
                keep = own_ok;
            end
            KIND_LREL: begin
                op   = OP_LREL;
                keep = own_ok;
            end
            KIND_RREQ: begin
                op   = OP_RREQ;
                keep = sender_ok;
            end
            KIND_RREP: begin
                op   = OP_RREP;
                keep = sender_ok;
            end
            KIND_RREL: begin
                op   = OP_RREL;
                keep = sender_ok;
            end
            default: begin
                op   = OP_LREQ;
                keep = 1'b0;
            end
        endcase
    end

    assign o_stall           = i_q_full;
    assign o_q_push          = i_valid && !i_q_full && keep;
    assign o_q_cmd.op        = op;
    assign o_q_cmd.stamp     = i_stamp;
    assign o_q_cmd.from_node = i_from_node;

endmodule

/* rtl/core/lmn_fifo.sv */
module lmn_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lmn_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lmn_pkg::t_cmd o_cmd
);
    import lmn_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_cmd             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [PTR_W:0]   n_count;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        do_push  = i_push && !o_full;
        do_pop   = i_pop && o_valid;
        n_wr_ptr = (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == (PTR_W + 1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

/* rtl/core/lmn_back.sv */
module lmn_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lmn_pkg::t_cfg   i_cfg,
    input  logic            i_q_valid,
    input  lmn_pkg::t_cmd   i_q_cmd,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output lmn_pkg::t_result o_result
);
    import lmn_pkg::*;

    logic [STAMP_W-1:0] r_clock;
    logic [NODES-1:0]   r_entry_valid;
    logic [STAMP_W-1:0] r_entry_stamp [NODES];
    logic [NODES-1:0]   r_reply_seen;
    logic               r_in_critical;
    logic               r_out_valid;
    t_result            r_out;
    logic               r_pend_valid;
    t_result            r_pend;

    logic [STAMP_W-1:0] n_clock;
    logic [NODES-1:0]   n_entry_valid;
    logic [STAMP_W-1:0] n_entry_stamp [NODES];
    logic [NODES-1:0]   n_reply_seen;
    logic               n_in_critical;

    logic               out_take;
    logic               can_pop;
    logic [ID_W-1:0]    me;
    logic               own_ok;
    logic [STAMP_W-1:0] base;
    logic [STAMP_W-1:0] clk_inc;
    logic               check;
    logic [NODES-1:0]   peers;
    logic               replies_ok;
    logic               front_ok;
    logic               grant;
    logic               has_a;
    logic               has_b;
    t_result            res_a;
    t_result            res_b;

    always_comb begin
        out_take = r_out_valid && !i_stall;
        can_pop  = i_q_valid && !r_pend_valid && (!r_out_valid || out_take);
        me       = i_cfg.own_id;
        own_ok   = int'(me) < NODES;

        // Local events tick the clock; received messages first catch up with the stamp.
        if (i_q_cmd.op == OP_LREQ || i_q_cmd.op == OP_LREL) begin
            base = r_clock;
        end else begin
            base = (r_clock > i_q_cmd.stamp) ? r_clock : i_q_cmd.stamp;
        end
        clk_inc = (base == CLOCK_MAX) ? CLOCK_MAX : base + 1'b1;

        n_clock       = r_clock;
        n_entry_valid = r_entry_valid;
        n_entry_stamp = r_entry_stamp;
        n_reply_seen  = r_reply_seen;
        n_in_critical = r_in_critical;
        check         = 1'b0;
        has_a         = 1'b0;
        res_a         = '{kind: OUT_REQ, stamp: clk_inc, dest: '0, last: 1'b1};

        case (i_q_cmd.op)
            OP_LREQ: begin
                if (!r_entry_valid[me]) begin
                    n_clock           = clk_inc;
                    n_entry_valid[me] = 1'b1;
                    n_entry_stamp[me] = clk_inc;
                    n_reply_seen      = '0;
                    check             = 1'b1;
                    has_a             = 1'b1;
                end
            end
            OP_LREL: begin
                if (r_entry_valid[me]) begin
                    n_clock           = clk_inc;
                    n_entry_valid[me] = 1'b0;
                    n_reply_seen      = '0;
                    n_in_critical     = 1'b0;
                    has_a             = 1'b1;
                    res_a.kind        = OUT_REL;
                end
            end
            OP_RREQ: begin
                n_clock                          = clk_inc;
                n_entry_valid[i_q_cmd.from_node] = 1'b1;
                n_entry_stamp[i_q_cmd.from_node] = i_q_cmd.stamp;
                has_a                            = 1'b1;
                res_a.kind                       = OUT_REP;
                res_a.dest                       = i_q_cmd.from_node;
            end
            OP_RREP: begin
                n_clock                         = clk_inc;
                n_reply_seen[i_q_cmd.from_node] = 1'b1;
                check                           = 1'b1;
            end
            OP_RREL: begin
                n_clock                          = clk_inc;
                n_entry_valid[i_q_cmd.from_node] = 1'b0;
                check                            = 1'b1;
            end
            default: begin
                check = 1'b0;
            end
        endcase

        // Grant test on the updated table: own entry first by stamp then id.
        peers      = i_cfg.member_mask & ~(NODES'(1) << me);
        replies_ok = (n_reply_seen & peers) == peers;
        front_ok   = n_entry_valid[me];
        for (int n = 0; n < NODES; n++) begin
            if (n != int'(me) && n_entry_valid[n] && i_cfg.member_mask[n]) begin
                if (n_entry_stamp[n] < n_entry_stamp[me]) begin
                    front_ok = 1'b0;
                end
                if (n_entry_stamp[n] == n_entry_stamp[me] && n < int'(me)) begin
                    front_ok = 1'b0;
                end
            end
        end
        grant = check && own_ok && !r_in_critical && replies_ok && front_ok;

        res_b = '{kind: OUT_GRANT, stamp: clk_inc, dest: '0, last: 1'b1};
        has_b = 1'b0;
        if (grant) begin
            n_in_critical = 1'b1;
            if (i_q_cmd.op == OP_LREQ) begin
                res_a.last = 1'b0;
                has_b      = 1'b1;
            end else begin
                res_a.kind = OUT_GRANT;
                has_a      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock       <= '0;
            r_entry_valid <= '0;
            r_reply_seen  <= '0;
            r_in_critical <= 1'b0;
            r_out_valid   <= 1'b0;
            r_pend_valid  <= 1'b0;
        end else if (can_pop) begin
            r_clock       <= n_clock;
            r_entry_valid <= n_entry_valid;
            r_reply_seen  <= n_reply_seen;
            r_in_critical <= n_in_critical;
            r_out_valid   <= has_a;
            r_pend_valid  <= has_b;
        end else if (out_take) begin
            r_out_valid  <= r_pend_valid;
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_pop) begin
            r_entry_stamp <= n_entry_stamp;
            r_out         <= res_a;
            r_pend        <= res_b;
        end else if (out_take) begin
            r_out <= r_pend;
        end
    end

    assign o_q_pop  = can_pop;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

/* rtl/core/lmn_chk.sv */
`include "lamport_mutex_node_defines.svh"

module lmn_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [lmn_pkg::OKIND_W-1:0] o_out_kind,
    input logic [lmn_pkg::STAMP_W-1:0] o_out_stamp,
    input logic [lmn_pkg::ID_W-1:0]    o_dest_node,
    input logic                        o_last
);
    import lmn_pkg::*;

    // A stalled result keeps its payload.
    property p_out_hold;
        o_valid && i_stall |=> o_valid && $stable(o_out_kind) && $stable(o_out_stamp)
            && $stable(o_dest_node) && $stable(o_last);
    endproperty

    // A result that is not the last one is followed at once by a grant with the same stamp.
    property p_pair_grant;
        o_valid && !i_stall && !o_last |=> o_valid && (o_out_kind == OUT_GRANT) && o_last
            && (o_out_stamp == $past(o_out_stamp));
    endproperty

    // Only a reply names a destination.
    property p_dest_zero;
        o_valid && (o_out_kind != OUT_REP) |-> (o_dest_node == '0);
    endproperty

    // Nothing is offered in the cycle after reset.
    property p_reset_idle;
        !i_rst_n |=> !o_valid;
    endproperty

    `LMN_ASSERT(a_out_hold, i_clk, !i_rst_n, p_out_hold)
    `LMN_ASSERT(a_pair_grant, i_clk, !i_rst_n, p_pair_grant)
    `LMN_ASSERT(a_dest_zero, i_clk, !i_rst_n, p_dest_zero)
    `LMN_ASSERT_ALWAYS(a_reset_idle, i_clk, p_reset_idle)

endmodule

bind lamport_mutex_node lmn_chk u_lmn_chk (.*);

/* dv/lamport_mutex_node_tb.sv */
// Shadow of one mutual exclusion node. It keeps its own logical clock, request
// table and reply bitmap. Each input transfer that the node accepts is noted
// here, and the results that the input should cause are queued in order. Each
// output transfer is then checked against the oldest queued result.
class t_mutex_scoreboard;

    logic [lmn_pkg::ID_W-1:0]    own_id;
    logic [lmn_pkg::NODES-1:0]   member_mask;
    logic [lmn_pkg::STAMP_W-1:0] lamport_time;
    bit                          entry_valid [lmn_pkg::NODES];
    logic [lmn_pkg::STAMP_W-1:0] entry_stamp [lmn_pkg::NODES];
    logic [lmn_pkg::NODES-1:0]   reply_seen;
    bit                          in_critical;

    lmn_pkg::t_result            owed [$];
    int                          errors;

    function new();
        own_id       = '0;
        member_mask  = '1;
        lamport_time = '0;
        reply_seen   = '0;
        in_critical  = 1'b0;
        errors       = 0;
        for (int n = 0; n < lmn_pkg::NODES; n++) begin
            entry_valid[n] = 1'b0;
            entry_stamp[n] = '0;
        end
    endfunction

    task report(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    function void set_reg(input logic [lmn_pkg::CFG_IDX_W-1:0]  idx,
                          input logic [lmn_pkg::CFG_DATA_W-1:0] data);
        if (idx == lmn_pkg::CFG_OWN_ID)
            own_id = data[lmn_pkg::ID_W-1:0];
        else if (idx == lmn_pkg::CFG_MEMBER_MASK)
            member_mask = data;
    endfunction

    function logic [lmn_pkg::STAMP_W-1:0] bump(input logic [lmn_pkg::STAMP_W-1:0] v);
        return (v == lmn_pkg::CLOCK_MAX) ? v : v + 1'b1;
    endfunction

    // Own request is at the head when no valid member entry beats it on stamp,
    // with the lower id winning a tie.
    function bit own_leads();
        int m;
        m = own_id;
        if (!entry_valid[m])
            return 1'b0;
        for (int n = 0; n < lmn_pkg::NODES; n++) begin
            if (n == m || !entry_valid[n] || !member_mask[n])
                continue;
            if (entry_stamp[n] < entry_stamp[m])
                return 1'b0;
            if (entry_stamp[n] == entry_stamp[m] && n < m)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function bit grant_due();
        logic [lmn_pkg::NODES-1:0] peers;
        peers = member_mask & ~(4'b0001 << own_id);
        if (in_critical || (reply_seen & peers) != peers || !own_leads())
            return 1'b0;
        in_critical = 1'b1;
        return 1'b1;
    endfunction

    function void owe(input logic [lmn_pkg::OKIND_W-1:0] kind,
                      input logic [lmn_pkg::ID_W-1:0] dest, input logic last);
        lmn_pkg::t_result r;
        r.kind  = kind;
        r.stamp = lamport_time;
        r.dest  = dest;
        r.last  = last;
        owed.push_back(r);
    endfunction

    function void note_input(input logic [lmn_pkg::KIND_W-1:0]  kind,
                             input logic [lmn_pkg::STAMP_W-1:0] stamp,
                             input logic [lmn_pkg::ID_W-1:0]    from);
        int m;
        m = own_id;
        if (kind == lmn_pkg::KIND_LREQ || kind == lmn_pkg::KIND_LREL) begin
            if (m >= lmn_pkg::NODES)
                return;
            if (kind == lmn_pkg::KIND_LREQ) begin
                if (entry_valid[m])
                    return;
                lamport_time   = bump(lamport_time);
                entry_valid[m] = 1'b1;
                entry_stamp[m] = lamport_time;
                reply_seen     = '0;
                if (grant_due()) begin
                    owe(lmn_pkg::OUT_REQ, 2'd0, 1'b0);
                    owe(lmn_pkg::OUT_GRANT, 2'd0, 1'b1);
                end else begin
                    owe(lmn_pkg::OUT_REQ, 2'd0, 1'b1);
                end
                return;
            end
            if (!entry_valid[m])
                return;
            lamport_time   = bump(lamport_time);
            entry_valid[m] = 1'b0;
            reply_seen     = '0;
            in_critical    = 1'b0;
            owe(lmn_pkg::OUT_REL, 2'd0, 1'b1);
            return;
        end
        if (kind > lmn_pkg::KIND_RREL)
            return;
        if (int'(from) >= lmn_pkg::NODES || from == own_id || !member_mask[from])
            return;
        lamport_time = bump((lamport_time > stamp) ? lamport_time : stamp);
        if (kind == lmn_pkg::KIND_RREQ) begin
            entry_valid[from] = 1'b1;
            entry_stamp[from] = stamp;
            owe(lmn_pkg::OUT_REP, from, 1'b1);
            return;
        end
        if (kind == lmn_pkg::KIND_RREP)
            reply_seen[from] = 1'b1;
        else
            entry_valid[from] = 1'b0;
        if (m < lmn_pkg::NODES && grant_due())
            owe(lmn_pkg::OUT_GRANT, 2'd0, 1'b1);
    endfunction

    task check_result(input lmn_pkg::t_result got);
        lmn_pkg::t_result want;
        if (owed.size() == 0) begin
            report($sformatf("unlooked-for result kind %0d stamp %08h dest %0d",
                             got.kind, got.stamp, got.dest));
            return;
        end
        want = owed.pop_front();
        if (got.kind !== want.kind)
            report($sformatf("out_kind %0d, wanted %0d", got.kind, want.kind));
        if (got.stamp !== want.stamp)
            report($sformatf("out_stamp %08h, wanted %08h", got.stamp, want.stamp));
        if (got.dest !== want.dest)
            report($sformatf("dest_node %0d, wanted %0d", got.dest, want.dest));
        if (got.last !== want.last)
            report($sformatf("last %0b, wanted %0b", got.last, want.last));
    endtask

endclass

module lamport_mutex_node_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lmn_pkg::*;

    // Kinds beyond the defined set; the node has to drop them silently.
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    // Items can sit in the node's input queue and back end without producing
    // anything, so after the last result we still let them drain before touching
    // the configuration or finishing.
    localparam int SETTLE_CYCLES = 8;
    // Cycles without a single transfer on any channel before we give up.
    localparam int IDLE_LIMIT    = 4000;
    // Items sent per random phase; nine phases in all.
    localparam int PHASE_ITEMS   = 150;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_WAVE
    } t_stall_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [KIND_W-1:0]     i_kind      = '0;
    logic [STAMP_W-1:0]    i_stamp     = '0;
    logic [ID_W-1:0]       i_from_node = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic [OKIND_W-1:0]    o_out_kind;
    logic [STAMP_W-1:0]    o_out_stamp;
    logic [ID_W-1:0]       o_dest_node;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    t_mutex_scoreboard sb = new();

    t_result     seen;
    bit          progress;
    int          idle_cycles = 0;
    logic [15:0] stall_tick  = '0;
    t_stall_mode stall_mode  = STALL_NONE;

    lamport_mutex_node uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_stamp     (i_stamp),
        .i_from_node (i_from_node),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_kind  (o_out_kind),
        .o_out_stamp (o_out_stamp),
        .o_dest_node (o_dest_node),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Output back-pressure. The stall behaviour is picked anew when the low byte
    // of stall_tick wraps: none at all, the odd stall, mostly stalled or a regular
    // square wave, so stalls land on every phase of the node's two-result sequences.
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1'b1;
        if (stall_tick[7:0] == 8'd0)
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 7) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= stall_tick[2];
        endcase
    end

    // Monitor. Everything is sampled at the rising edge, before any of this
    // edge's nonblocking updates land, so the values seen are those that the
    // node itself acted on. A result transfer is checked before the input
    // transfer of the same edge is noted; the node cannot answer an input at the
    // edge that accepts it, so the order only matters for clarity. The watchdog
    // lives here too, since it needs to know whether anything moved.
    always @(posedge i_clk) begin
        progress = 1'b0;
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                seen.kind  = o_out_kind;
                seen.stamp = o_out_stamp;
                seen.dest  = o_dest_node;
                seen.last  = o_last;
                sb.check_result(seen);
                progress = 1'b1;
            end
            if (i_valid && o_stall === 1'b0) begin
                sb.note_input(i_kind, i_stamp, i_from_node);
                progress = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                sb.set_reg(i_cfg_index, i_cfg_data);
                progress = 1'b1;
            end
        end
        idle_cycles = progress ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Presents one item and holds it, unchanged, until the node takes the
    // transfer. Valid is left high so that a following item in the same burst
    // goes out back to back.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [STAMP_W-1:0] stamp,
                             input logic [ID_W-1:0] from);
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_stamp     <= stamp;
        i_from_node <= from;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
    endtask

    // Leaves valid high on return; the caller drops it once all writes are in.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1)
            @(posedge i_clk);
    endtask

    // Stops sending and waits until every queued result has come out, then
    // lets items that produce nothing work their way through the pipeline.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Registers may only change while the node is idle.
    task automatic configure(input logic [ID_W-1:0] id, input logic [NODES-1:0] mask);
        settle();
        write_reg(CFG_OWN_ID, CFG_DATA_W'(id));
        write_reg(CFG_MEMBER_MASK, mask);
        i_cfg_valid <= 1'b0;
    endtask

    // A stamp close to the node's current clock, a little behind or ahead, so
    // that received requests compete with our own on the table.
    function automatic logic [STAMP_W-1:0] near_stamp();
        logic [STAMP_W-1:0] base;
        base = sb.lamport_time;
        if (base > CLOCK_MAX - 16)
            return base;
        if (base < 4)
            return base + $urandom_range(0, 4);
        return base - 3 + $urandom_range(0, 7);
    endfunction

    // A member peer, taken from the preferred set where it holds one. With no
    // member peers at all, any id other than our own.
    function automatic logic [ID_W-1:0] pick_peer(input logic [NODES-1:0] prefer);
        logic [NODES-1:0] peers;
        logic [NODES-1:0] pool;
        logic [ID_W-1:0]  id;
        peers = sb.member_mask & ~(4'b0001 << sb.own_id);
        pool  = ((peers & prefer) != '0) ? (peers & prefer) : peers;
        if (pool == '0) begin
            id = sb.own_id + ID_W'($urandom_range(1, 3));
            return id;
        end
        do
            id = ID_W'($urandom_range(0, NODES - 1));
        while (!pool[id]);
        return id;
    endfunction

    // Picks the next item from what the node ought to be doing now. The bulk are
    // well-formed protocol rounds: request, replies from peers that have not yet
    // answered, releases that clear competing entries, then our own release.
    // About one item in twelve is pure noise with a random kind, sender and
    // stamp. The shadow state may lag the driver by an item or two; that only
    // bends the odds, never the checking.
    task automatic choose_item(output logic [KIND_W-1:0] kind, output logic [STAMP_W-1:0] stamp,
                               output logic [ID_W-1:0] from);
        int               roll;
        logic [NODES-1:0] held;
        bit               mine;
        roll = $urandom_range(0, 99);
        for (int n = 0; n < NODES; n++)
            held[n] = sb.entry_valid[n];
        mine  = held[sb.own_id];
        stamp = near_stamp();
        from  = pick_peer('1);
        if (roll < 8) begin
            kind  = KIND_W'($urandom_range(0, 7));
            stamp = $urandom;
            from  = ID_W'($urandom_range(0, NODES - 1));
        end else if (!mine) begin
            if (roll < 50) begin
                kind = KIND_LREQ;
            end else if (roll < 78) begin
                kind = KIND_RREQ;
            end else if (roll < 96) begin
                kind = KIND_RREL;
                from = pick_peer(held);
            end else begin
                kind = KIND_LREL;
            end
        end else if (!sb.in_critical) begin
            if (roll < 55) begin
                kind = KIND_RREP;
                from = pick_peer(~sb.reply_seen);
            end else if (roll < 72) begin
                kind = KIND_RREL;
                from = pick_peer(held);
            end else if (roll < 88) begin
                kind = KIND_RREQ;
            end else if (roll < 95) begin
                kind = KIND_LREL;
            end else begin
                kind = KIND_LREQ;
            end
        end else begin
            if (roll < 45)
                kind = KIND_LREL;
            else if (roll < 65)
                kind = KIND_RREQ;
            else if (roll < 82)
                kind = KIND_RREP;
            else
                kind = KIND_RREL;
        end
    endtask

    // Random traffic in bursts of up to two dozen back-to-back transfers, with
    // gaps of random length between them; a third of the gaps are empty so
    // that long unbroken stretches occur as well. Dropped items count toward
    // the phase as well.
    task automatic run_random(input int count);
        int                 sent;
        int                 burst;
        int                 gap;
        logic [KIND_W-1:0]  kind;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    from;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                if (sent < count) begin
                    choose_item(kind, stamp, from);
                    send_item(kind, stamp, from);
                    sent++;
                end
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Directed opening under the reset configuration: node 0, all four nodes
    // taking part, clock at zero.
    task automatic run_directed();
        // Dropped items: a release with nothing to release, unknown kinds, and
        // a message that claims to come from this node itself.
        send_item(KIND_LREL, 32'h0000_0000, 2'd0);
        send_item(KIND_UNUSED_LO, CLOCK_MAX, 2'd1);
        send_item(KIND_UNUSED_HI, 32'h0000_0000, 2'd3);
        send_item(KIND_RREQ, CLOCK_MAX, 2'd0);
        // A peer request with the smallest stamp is answered at once.
        send_item(KIND_RREQ, 32'h0000_0000, 2'd1);
        // Our own request, then a second one while it is pending, which is
        // dropped.
        send_item(KIND_LREQ, 32'h0000_0000, 2'd0);
        send_item(KIND_LREQ, 32'h0000_0000, 2'd0);
        // All replies in, but node 1 still holds an older request.
        send_item(KIND_RREP, 32'h0000_0010, 2'd2);
        send_item(KIND_RREP, 32'h0000_0005, 2'd3);
        send_item(KIND_RREP, 32'h0000_0012, 2'd1);
        // Node 3 ties with our stamp; the lower id wins, so it does not block.
        send_item(KIND_RREQ, 32'h0000_0002, 2'd3);
        // Node 1 releases: the grant follows.
        send_item(KIND_RREL, 32'h0000_0000, 2'd1);
        // A late reply while inside the critical section grants nothing more.
        send_item(KIND_RREP, 32'h0000_0001, 2'd2);
        send_item(KIND_LREL, 32'h0000_0000, 2'd0);
        send_item(KIND_RREL, 32'h0000_0000, 2'd3);
        // A fresh request that an older peer request keeps waiting, then
        // cancelled by our own release before it is ever granted.
        send_item(KIND_LREQ, 32'h0000_0000, 2'd0);
        send_item(KIND_RREQ, 32'h0000_0001, 2'd2);
        send_item(KIND_RREP, 32'h0000_0000, 2'd1);
        send_item(KIND_RREP, 32'h0000_0000, 2'd2);
        send_item(KIND_RREP, 32'h0000_0000, 2'd3);
        send_item(KIND_LREL, 32'h0000_0000, 2'd0);
        send_item(KIND_RREL, 32'h0000_0000, 2'd2);
        send_item(KIND_UNUSED_LO + 3'd1, 32'h5555_5555, 2'd2);
    endtask

    // Clock overflow, kept for the very end because the clock never leaves its
    // ceiling once there. Runs as node 1 with node 0 as the only peer.
    task automatic run_overflow();
        if (sb.entry_valid[1])
            send_item(KIND_LREL, 32'h0000_0000, 2'd0);
        send_item(KIND_RREL, 32'h0000_0000, 2'd0);
        send_item(KIND_RREQ, CLOCK_MAX - 1, 2'd0);
        send_item(KIND_RREQ, CLOCK_MAX, 2'd0);
        // Our stamp saturates and ties with node 0, which wins on id.
        send_item(KIND_LREQ, 32'h0000_0000, 2'd0);
        send_item(KIND_RREP, 32'h0000_0003, 2'd0);
        send_item(KIND_RREL, 32'h0000_0000, 2'd0);
        send_item(KIND_LREL, 32'h0000_0000, 2'd0);
    endtask

    // Phases: the reset setting, both extreme ids with everyone in, a node that
    // is alone (granted at once), a node outside an empty mask (every received
    // message dropped), partial masks, three random settings and the overflow
    // check at the close.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random(PHASE_ITEMS);
        configure(2'd3, 4'b1111);
        run_random(PHASE_ITEMS);
        configure(2'd1, 4'b0010);
        run_random(PHASE_ITEMS);
        configure(2'd2, 4'b0000);
        run_random(PHASE_ITEMS);
        configure(2'd0, 4'b1011);
        run_random(PHASE_ITEMS);
        configure(2'd3, 4'b1001);
        run_random(PHASE_ITEMS);
        repeat (3) begin
            configure(ID_W'($urandom_range(0, 3)), NODES'($urandom_range(0, 15)));
            run_random(PHASE_ITEMS);
        end
        configure(2'd1, 4'b0011);
        run_overflow();
        settle();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lmn_pkg.sv
rtl/core/lmn_front.sv
rtl/core/lmn_fifo.sv
rtl/core/lmn_back.sv
rtl/core/lamport_mutex_node.sv
rtl/core/lmn_chk.sv
dv/lamport_mutex_node_tb.sv
